/* rtl/signed_decimal_seven_segment_driver_top_defines.svh */
// assertion macros for the signed decimal seven-segment driver
// used by the top level only; expects clk and arst_n in scope
`ifndef SIGNED_DECIMAL_SEVEN_SEGMENT_DRIVER_TOP_DEFINES_SVH
`define SIGNED_DECIMAL_SEVEN_SEGMENT_DRIVER_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define SDSEG_ASSERT_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("sdsegdrv check failed");
`define SDSEG_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sdsegdrv check failed");
`define SDSEG_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sdsegdrv check failed");
`else
`define SDSEG_ASSERT_NEVER(lbl, cond)
`define SDSEG_ASSERT_IMP(lbl, ante, cons)
`define SDSEG_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* rtl/sdsegdrv_pkg.sv */
// shared types and constants for the signed decimal seven-segment driver
// no dependencies
package sdsegdrv_pkg;

	localparam int unsigned VALUE_W = 16;
	localparam int unsigned SEG_W   = 7;
	localparam int unsigned POS_W   = 2;
	localparam int unsigned TDATA_W = 16;

	// reciprocal of ten, exact for 16-bit dividends with a 19-bit shift
	localparam logic [15:0] RECIP_10 = 16'hCCCD;
	localparam int unsigned RECIP_SHIFT = 19;

	localparam logic [SEG_W-1:0] SEG_MINUS = 7'h40;
	localparam logic [SEG_W-1:0] SEG_ALL   = 7'h7F;

	typedef struct packed {
		logic                negative;
		logic [VALUE_W-1:0] mag;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	function automatic logic [SEG_W-1:0] digit_glyph(input logic [3:0] d);
		logic [SEG_W-1:0] g;
		unique case (d)
			4'd0: g = 7'h3F;
			4'd1: g = 7'h06;
			4'd2: g = 7'h5B;
			4'd3: g = 7'h4F;
			4'd4: g = 7'h66;
			4'd5: g = 7'h6D;
			4'd6: g = 7'h7D;
			4'd7: g = 7'h07;
			4'd8: g = 7'h7F;
			4'd9: g = 7'h6F;
			default: g = '0;
		endcase
		return g;
	endfunction

endpackage

/* rtl/signed_decimal_seven_segment_driver_top.sv */
// top level of the signed decimal seven-segment scan driver
// depends on sdsegdrv_pkg, sdsegdrv_front, sdsegdrv_queue, sdsegdrv_back
//
// channel   dir  fields (low bit first)
// s_*       in   tdata: display_value[15:0]
// m_*       out  tdata: digit_position[1:0], segment_levels[8:2]; tlast: last_digit
// cfg_*     in   cfg_wdata: common_anode
//
// each value gives NUM_DIGITS results, one per cycle from the digit sequencer while
// the output is not stalled; the divide-by-ten step sets this pace.
// an input value passes the queue, the sequencer and the output register in turn.
// reset clears the queue, the sequencer and common_anode; no clearing pass.
// the two-entry queue lets input transfers continue while the output stalls.
`include "signed_decimal_seven_segment_driver_top_defines.svh"
module signed_decimal_seven_segment_driver_top
	import sdsegdrv_pkg::*;
#(
	parameter int NUM_DIGITS = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_wdata,  // common_anode
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [VALUE_W-1:0] s_tdata,    // display_value[15:0]
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,    // digit_position[1:0], segment_levels[8:2]
	output logic               m_tlast     // last_digit
);

	logic   common_anode_q;
	qstat_t qstat;
	logic   push;
	item_t  push_item;
	logic   pop;
	item_t  pop_item;

	logic [POS_W-1:0] m_pos;
	logic             m_mid_xfer;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			common_anode_q <= 1'b0;
		else if (cfg_we)
			common_anode_q <= cfg_wdata;
	end

	sdsegdrv_front u_front (
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.qstat     (qstat),
		.push      (push),
		.push_item (push_item)
	);

	sdsegdrv_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.qstat     (qstat)
	);

	sdsegdrv_back #(
		.NUM_DIGITS (NUM_DIGITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.common_anode (common_anode_q),
		.qstat        (qstat),
		.pop_item     (pop_item),
		.pop          (pop),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tlast      (m_tlast)
	);

	// result transfer that is not the end of a scan
	assign m_pos      = m_tdata[POS_W-1:0];
	assign m_mid_xfer = m_tvalid && m_tready && !m_tlast;

	`SDSEG_ASSERT_NEVER(a_no_overflow, push && qstat.full)
	`SDSEG_ASSERT_NEVER(a_no_underflow, pop && qstat.empty)
	`SDSEG_ASSERT_IMP(a_last_position, m_tvalid && m_tlast, m_pos == 2'((NUM_DIGITS - 1) % 4))
	`SDSEG_ASSERT_NEXT(a_scan_advances, m_mid_xfer, !m_tvalid || m_pos == $past(m_pos) + 2'd1)

endmodule

/* rtl/sdsegdrv_front.sv */
// front end: accepts input values and splits them into sign and magnitude
// depends on sdsegdrv_pkg
module sdsegdrv_front
	import sdsegdrv_pkg::*;
(
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [VALUE_W-1:0] s_tdata,
	input  qstat_t             qstat,
	output logic               push,
	output item_t              push_item
);

	logic negative;

	assign negative = s_tdata[VALUE_W-1];
	assign s_tready = !qstat.full;
	assign push     = s_tvalid && s_tready;

	// two's complement negate; the most negative value maps to 0x8000
	assign push_item.negative = negative;
	assign push_item.mag      = negative ? (~s_tdata + VALUE_W'(1)) : s_tdata;

endmodule

/* rtl/sdsegdrv_queue.sv */
// two-entry queue between the front end and the digit sequencer
// depends on sdsegdrv_pkg
module sdsegdrv_queue
	import sdsegdrv_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  item_t  push_item,
	input  logic   pop,
	output item_t  pop_item,
	output qstat_t qstat
);

	item_t       mem_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;

	assign qstat.full  = (count_q == 2'd2);
	assign qstat.empty = (count_q == 2'd0);
	assign pop_item    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			if (push && !pop)
				count_q <= count_q + 2'd1;
			else if (pop && !push)
				count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_item;
	end

endmodule

/* rtl/sdsegdrv_back.sv */
// back end: peels one decimal digit per cycle while the output is not stalled and drives the output register
// depends on sdsegdrv_pkg
module sdsegdrv_back
	import sdsegdrv_pkg::*;
#(
	parameter int NUM_DIGITS = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               common_anode,
	input  qstat_t             qstat,
	input  item_t              pop_item,
	output logic               pop,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,
	output logic               m_tlast
);

	localparam int PW = ($clog2(NUM_DIGITS) < 2) ? 2 : $clog2(NUM_DIGITS);
	localparam logic [PW-1:0] LAST_POS = PW'(NUM_DIGITS - 1);

	logic               cur_valid_q;
	logic [VALUE_W-1:0] mag_q;
	logic               neg_q;
	logic [PW-1:0]      pos_q;

	logic               out_valid_q;
	logic [POS_W-1:0]   out_pos_q;
	logic [SEG_W-1:0]   out_seg_q;
	logic               out_last_q;

	logic               advance;
	logic               emit;
	logic               is_last;
	logic [31:0]        prod;
	logic [VALUE_W-1:0] quot;
	logic [VALUE_W-1:0] diff;
	logic [SEG_W-1:0]   seg_raw;

	assign advance = !out_valid_q || m_tready;
	assign emit    = cur_valid_q && advance;
	assign is_last = (pos_q == LAST_POS);
	assign pop     = !qstat.empty && (!cur_valid_q || (emit && is_last));

	// divide by ten via reciprocal, remainder by shift-add
	assign prod = 32'(mag_q) * 32'(RECIP_10);
	assign quot = VALUE_W'(prod >> RECIP_SHIFT);
	assign diff = mag_q - (quot << 3) - (quot << 1);

	always_comb begin
		if (is_last && neg_q)
			seg_raw = SEG_MINUS;
		else
			seg_raw = digit_glyph(diff[3:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop)
				cur_valid_q <= 1'b1;
			else if (emit && is_last)
				cur_valid_q <= 1'b0;
			if (advance)
				out_valid_q <= cur_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			mag_q <= pop_item.mag;
			neg_q <= pop_item.negative;
			pos_q <= '0;
		end else if (emit) begin
			mag_q <= quot;
			pos_q <= pos_q + PW'(1);
		end
		if (emit) begin
			out_pos_q  <= pos_q[POS_W-1:0];
			out_seg_q  <= common_anode ? (seg_raw ^ SEG_ALL) : seg_raw;
			out_last_q <= is_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {{(TDATA_W - POS_W - SEG_W){1'b0}}, out_seg_q, out_pos_q};

endmodule

/* tb/sv/signed_decimal_seven_segment_driver_top_test.sv */
// self-checking testbench for signed_decimal_seven_segment_driver_top
// predicts the four digit patterns of every display value and checks each result transfer
// depends on sdsegdrv_pkg and the driver rtl only
module signed_decimal_seven_segment_driver_top_test;
	import sdsegdrv_pkg::*;

	localparam int DIGITS         = 4;
	localparam int RADIX          = 10;
	localparam int SETTLE_CYCLES  = 8;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int MAX_REPORTS    = 40;
	localparam int PHASE_ITEMS    = 28;

	// lit segments of digits 0 to 9, bit0 is segment a
	localparam logic [SEG_W-1:0] SEGMENT_FONT [RADIX] = '{
		7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
	};

	typedef struct {
		logic [VALUE_W-1:0] value;
		logic [POS_W-1:0]   pos;
		logic [SEG_W-1:0]   seg;
		logic               last;
	} scan_digit_t;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               cfg_we    = 1'b0;
	logic               cfg_wdata = 1'b0;
	logic               s_tvalid  = 1'b0;
	logic               s_tready;
	logic [VALUE_W-1:0] s_tdata   = '0;    // display_value[15:0]
	logic               m_tvalid;
	logic               m_tready  = 1'b0;
	logic [TDATA_W-1:0] m_tdata;           // digit_position[1:0], segment_levels[8:2]
	logic               m_tlast;           // last_digit

	scan_digit_t digit_queue[$];
	logic        anode_model = 1'b0;
	int          sender_idle_pct = 0;
	int          recv_stall_pct  = 0;
	int          errors = 0;
	int          values_sent = 0;
	int          digits_checked = 0;
	int          phases_done = 0;
	int          idle_cycles = 0;

	signed_decimal_seven_segment_driver_top #(
		.NUM_DIGITS(DIGITS)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] value,
			input int got, input int want);
		errors++;
		if (errors <= MAX_REPORTS)
			$display("mismatch %s for value %0d: got %0h expected %0h",
				what, $signed(value), got, want);
	endtask

	// expected scan of one value: ones first, sign or thousands last
	function automatic void predict_scan(input logic [VALUE_W-1:0] value);
		int          mag;
		logic        neg;
		logic [SEG_W-1:0] glyph;
		scan_digit_t d;
		neg = value[VALUE_W-1];
		mag = neg ? (32'h10000 - int'(value)) : int'(value);
		for (int i = 0; i < DIGITS; i++) begin
			if (i == DIGITS - 1 && neg) begin
				glyph = SEG_MINUS;
			end else begin
				glyph = SEGMENT_FONT[mag % RADIX];
				mag = mag / RADIX;
			end
			d.value = value;
			d.pos   = i[POS_W-1:0];
			d.seg   = anode_model ? ~glyph : glyph;
			d.last  = (i == DIGITS - 1);
			digit_queue.push_back(d);
		end
	endfunction

	always @(posedge clk) begin
		scan_digit_t want;
		if (m_tvalid && m_tready) begin
			if (digit_queue.size() == 0) begin
				report_mismatch("unexpected transfer", '0, int'(m_tdata), 0);
			end else begin
				want = digit_queue.pop_front();
				digits_checked++;
				if (m_tdata[POS_W-1:0] !== want.pos)
					report_mismatch("digit_position", want.value,
						int'(m_tdata[POS_W-1:0]), int'(want.pos));
				if (m_tdata[POS_W+SEG_W-1:POS_W] !== want.seg)
					report_mismatch("segment_levels", want.value,
						int'(m_tdata[POS_W+SEG_W-1:POS_W]), int'(want.seg));
				if (m_tlast !== want.last)
					report_mismatch("last_digit", want.value, int'(m_tlast), int'(want.last));
				if (m_tdata[TDATA_W-1:POS_W+SEG_W] !== '0)
					report_mismatch("tdata padding", want.value,
						int'(m_tdata[TDATA_W-1:POS_W+SEG_W]), 0);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: %0d cycles without a transfer", idle_cycles);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// called and returns at a falling edge
	task automatic send_value(input logic [VALUE_W-1:0] v);
		while ($urandom_range(99) < sender_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= v;
		do @(posedge clk); while (!s_tready);
		predict_scan(v);
		values_sent++;
		@(negedge clk);
	endtask

	task automatic wait_all_results();
		s_tvalid <= 1'b0;
		while (digit_queue.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// only while idle
	task automatic write_polarity(input logic anode);
		cfg_we    <= 1'b1;
		cfg_wdata <= anode;
		@(negedge clk);
		cfg_we <= 1'b0;
		anode_model = anode;
	endtask

	task automatic test_edge_values();
		logic [VALUE_W-1:0] edge_list[$];
		edge_list = '{16'd0, 16'd1, 16'hFFFF, 16'd9, 16'd10, 16'd99, 16'd100, 16'd999,
			16'd1000, -16'sd999, -16'sd1000, 16'd9999, 16'd10000, 16'h7FFF, 16'h8000,
			16'h8001, 16'd1234, 16'd5678, -16'sd90, 16'h5555, 16'hAAAA};
		sender_idle_pct = 0;
		recv_stall_pct  = 0;
		write_polarity(1'b0);
		foreach (edge_list[i])
			send_value(edge_list[i]);
		wait_all_results();
	endtask

	task automatic test_anode_edges();
		write_polarity(1'b1);
		send_value(16'd8);
		send_value(16'hFFFF);
		send_value(16'h7FFF);
		send_value(16'h8000);
		wait_all_results();
	endtask

	task automatic test_random_phase(input int idle_pct, input int stall_pct,
			input logic anode, input bit pause_midway);
		logic [VALUE_W-1:0] v;
		sender_idle_pct = idle_pct;
		recv_stall_pct  = stall_pct;
		write_polarity(anode);
		for (int i = 0; i < PHASE_ITEMS; i++) begin
			// hold off until the display has drained completely
			if (pause_midway && i == PHASE_ITEMS / 2)
				wait_all_results();
			case ($urandom_range(3))
				0: v = VALUE_W'($urandom_range(16'hFFFF));
				1: v = VALUE_W'($urandom_range(9999));
				2: v = VALUE_W'(0 - $urandom_range(1, 999));
				default: begin
					v = VALUE_W'($urandom_range(1000, 32767));
					if ($urandom_range(1))
						v = VALUE_W'(0) - v;
				end
			endcase
			send_value(v);
		end
		wait_all_results();
		phases_done++;
	endtask

	initial begin
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_edge_values();
		test_anode_edges();
		test_random_phase(0, 0, 1'b0, 1'b1);
		test_random_phase(88, 0, 1'b1, 1'b0);
		test_random_phase(0, 88, 1'b0, 1'b0);
		test_random_phase(24, 24, 1'b1, 1'b0);
		$display("sent %0d values (edges, sign, overflow, both polarities), checked %0d digits",
			values_sent, digits_checked);
		$display("%0d random phases with sender gaps and receiver stalls, %0d mismatches",
			phases_done, errors);
		if (errors == 0 && digit_queue.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

/* files.f */
+incdir+rtl
rtl/sdsegdrv_pkg.sv
rtl/sdsegdrv_front.sv
rtl/sdsegdrv_queue.sv
rtl/sdsegdrv_back.sv
rtl/signed_decimal_seven_segment_driver_top.sv
tb/sv/signed_decimal_seven_segment_driver_top_test.sv
